// ----- rtl/gdbt_pkg.sv -----
// shared constants and codes for the graph traversal block
package gdbt_pkg;

  // field widths of the stream payloads
  localparam int VERTEX_W   = 6;
  localparam int ACTION_W   = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 8;

  // default graph size
  localparam int DEF_MAX_VERTICES = 64;

  // action codes carried on s_tuser
  localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DFS      = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BFS      = 2'd3;

endpackage

// ----- rtl/gdbt_ffs.sv -----
// find-first-set unit shared by both walks: lowest set bit of a candidate row
module gdbt_ffs #(
  parameter int WIDTH = 64,
  parameter int IDX_W = 6
) (
  input  logic [WIDTH-1:0] vec,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  // priority encode, lowest index wins
  always_comb begin
    idx   = '0;
    found = |vec;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

// ----- rtl/graph_dfs_bfs_traversal.sv -----
// graph traversal top level: adjacency memory, walk stack/queue and sequencer
// add edge: reads and updates row a, then row b; remove vertex: sweeps all rows, one row per cycle.
// depth-first walk: pushes each discovered vertex, emits it in discovery order, pops to backtrack.
// breadth-first walk: enqueues each discovered vertex, emits vertices in dequeue order.
// a walk holds while the output is stalled; candidates come from the ffs unit and 1 read port.
// s_tready is low while an item is at work; rst clears control and row valid bits at once.
module graph_dfs_bfs_traversal #(
  parameter int MAX_VERTICES = gdbt_pkg::DEF_MAX_VERTICES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gdbt_pkg::S_TDATA_W-1:0] s_tdata,   // vertex_a [5:0], vertex_b [11:6], zero pad
  input  logic [gdbt_pkg::ACTION_W-1:0]  s_tuser,   // action [1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gdbt_pkg::M_TDATA_W-1:0] m_tdata,   // visited_vertex [5:0], zero pad
  output logic                           m_tlast
);

  import gdbt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int PW = AW + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_WA   = 4'd1;
  localparam logic [3:0] S_ADD_RB   = 4'd2;
  localparam logic [3:0] S_ADD_WB   = 4'd3;
  localparam logic [3:0] S_REM      = 4'd4;
  localparam logic [3:0] S_DFS_EV   = 4'd5;
  localparam logic [3:0] S_DFS_POP  = 4'd6;
  localparam logic [3:0] S_BFS_SCAN = 4'd7;
  localparam logic [3:0] S_BFS_DEQ  = 4'd8;
  localparam logic [3:0] S_FLUSH    = 4'd9;

  typedef logic [MAX_VERTICES-1:0] row_t;

  localparam row_t ONE_ROW = row_t'(1);

  logic [3:0]          state, state_next;
  logic [VERTEX_W-1:0] op_a, op_b;
  logic [PW-1:0]       sweep, sweep_next;
  logic [PW-1:0]       sp, sp_next;
  logic [PW-1:0]       head, head_next;
  logic [PW-1:0]       tail, tail_next;
  row_t                visited, visited_next;
  logic [VERTEX_W-1:0] pend, pend_next;

  // adjacency memory and its per-row valid bits
  row_t                adj_mem [MAX_VERTICES];
  row_t                row_valid;
  row_t                adj_q;
  logic                adj_q_ok;
  logic                adj_re, adj_we;
  logic [AW-1:0]       adj_ra, adj_wa;
  row_t                adj_wd;
  row_t                row;

  // walk stack / queue memory
  logic [AW-1:0]       walk_mem [MAX_VERTICES];
  logic [AW-1:0]       walk_q;
  logic                walk_re, walk_we;
  logic [AW-1:0]       walk_ra, walk_wa, walk_wd;

  // output staging
  logic                out_free, out_load, out_last;
  logic [VERTEX_W-1:0] out_vertex;

  // input decode
  logic                s_acc;
  logic [VERTEX_W-1:0] in_a, in_b;
  logic                in_a_ok, in_b_ok;

  // shared search unit
  row_t                cand;
  logic                cand_any;
  logic [AW-1:0]       cand_idx;
  row_t                cand_mask;
  row_t                a_mask, b_mask;
  logic [PW-1:0]       sweep_m1, sp_m2;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_a     = s_tdata[VERTEX_W-1:0];
  assign in_b     = s_tdata[2*VERTEX_W-1:VERTEX_W];
  assign in_a_ok  = {1'b0, in_a} < (VERTEX_W + 1)'(MAX_VERTICES);
  assign in_b_ok  = {1'b0, in_b} < (VERTEX_W + 1)'(MAX_VERTICES);

  assign row       = adj_q_ok ? adj_q : '0;
  assign cand      = row & ~visited;
  assign cand_mask = ONE_ROW << cand_idx;
  assign a_mask    = ONE_ROW << op_a[AW-1:0];
  assign b_mask    = ONE_ROW << op_b[AW-1:0];
  assign sweep_m1  = sweep - PW'(1);
  assign sp_m2     = sp - PW'(2);
  assign out_free  = !m_tvalid || m_tready;

  gdbt_ffs #(
    .WIDTH (MAX_VERTICES),
    .IDX_W (AW)
  ) u_ffs (
    .vec   (cand),
    .found (cand_any),
    .idx   (cand_idx)
  );

  // sequencer
  always_comb begin
    state_next   = state;
    sweep_next   = sweep;
    sp_next      = sp;
    head_next    = head;
    tail_next    = tail;
    visited_next = visited;
    pend_next    = pend;
    adj_re       = 1'b0;
    adj_ra       = '0;
    adj_we       = 1'b0;
    adj_wa       = '0;
    adj_wd       = '0;
    walk_re      = 1'b0;
    walk_ra      = '0;
    walk_we      = 1'b0;
    walk_wa      = '0;
    walk_wd      = '0;
    out_load     = 1'b0;
    out_vertex   = pend;
    out_last     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          unique case (s_tuser)
            ACT_ADD_EDGE: begin
              if (in_a_ok && in_b_ok) begin
                adj_re     = 1'b1;
                adj_ra     = in_a[AW-1:0];
                state_next = S_ADD_WA;
              end
            end
            ACT_REMOVE: begin
              if (in_a_ok) begin
                sweep_next = '0;
                state_next = S_REM;
              end
            end
            ACT_DFS: begin
              visited_next = ONE_ROW;
              pend_next    = '0;
              sp_next      = PW'(1);
              walk_we      = 1'b1;
              adj_re       = 1'b1;
              state_next   = S_DFS_EV;
            end
            ACT_BFS: begin
              visited_next = ONE_ROW;
              pend_next    = '0;
              head_next    = PW'(1);
              tail_next    = PW'(1);
              walk_we      = 1'b1;
              adj_re       = 1'b1;
              state_next   = S_BFS_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_WA: begin
        adj_we     = 1'b1;
        adj_wa     = op_a[AW-1:0];
        adj_wd     = row | b_mask;
        state_next = S_ADD_RB;
      end
      S_ADD_RB: begin
        adj_re     = 1'b1;
        adj_ra     = op_b[AW-1:0];
        state_next = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_we     = 1'b1;
        adj_wa     = op_b[AW-1:0];
        adj_wd     = row | a_mask;
        state_next = S_IDLE;
      end
      S_REM: begin
        // read row k while writing back row k-1 with the column cleared
        if (sweep < PW'(MAX_VERTICES)) begin
          adj_re = 1'b1;
          adj_ra = sweep[AW-1:0];
        end else begin
          state_next = S_IDLE;
        end
        if (sweep != '0) begin
          adj_we = 1'b1;
          adj_wa = sweep_m1[AW-1:0];
          adj_wd = row & ~a_mask;
        end
        sweep_next = sweep + PW'(1);
      end
      S_DFS_EV: begin
        if (cand_any) begin
          if (out_free) begin
            out_load     = 1'b1;
            pend_next    = VERTEX_W'(cand_idx);
            visited_next = visited | cand_mask;
            walk_we      = 1'b1;
            walk_wa      = sp[AW-1:0];
            walk_wd      = cand_idx;
            sp_next      = sp + PW'(1);
            adj_re       = 1'b1;
            adj_ra       = cand_idx;
          end
        end else if (sp == PW'(1)) begin
          sp_next    = '0;
          state_next = S_FLUSH;
        end else begin
          walk_re    = 1'b1;
          walk_ra    = sp_m2[AW-1:0];
          sp_next    = sp - PW'(1);
          state_next = S_DFS_POP;
        end
      end
      S_DFS_POP: begin
        adj_re     = 1'b1;
        adj_ra     = walk_q;
        state_next = S_DFS_EV;
      end
      S_BFS_SCAN: begin
        if (cand_any) begin
          visited_next = visited | cand_mask;
          walk_we      = 1'b1;
          walk_wa      = tail[AW-1:0];
          walk_wd      = cand_idx;
          tail_next    = tail + PW'(1);
        end else if (head < tail) begin
          walk_re    = 1'b1;
          walk_ra    = head[AW-1:0];
          head_next  = head + PW'(1);
          state_next = S_BFS_DEQ;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_BFS_DEQ: begin
        if (out_free) begin
          out_load   = 1'b1;
          pend_next  = VERTEX_W'(walk_q);
          adj_re     = 1'b1;
          adj_ra     = walk_q;
          state_next = S_BFS_SCAN;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sweep   <= '0;
      sp      <= '0;
      head    <= '0;
      tail    <= '0;
      visited <= '0;
    end else begin
      state   <= state_next;
      sweep   <= sweep_next;
      sp      <= sp_next;
      head    <= head_next;
      tail    <= tail_next;
      visited <= visited_next;
    end
  end

  // operands and pending vertex
  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_a <= in_a;
      op_b <= in_b;
    end
    pend <= pend_next;
  end

  // adjacency row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (adj_we) begin
      row_valid[adj_wa] <= 1'b1;
    end
  end

  // adjacency memory, registered read
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_q    <= adj_mem[adj_ra];
      adj_q_ok <= row_valid[adj_ra];
    end
  end

  // walk stack / queue memory, registered read
  always_ff @(posedge clk) begin
    if (walk_we) begin
      walk_mem[walk_wa] <= walk_wd;
    end
    if (walk_re) begin
      walk_q <= walk_mem[walk_ra];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= M_TDATA_W'(out_vertex);
      m_tlast <= out_last;
    end
  end

`ifndef SYNTH
  // the stack never holds more entries than there are vertices
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DFS_EV || state == S_DFS_POP) |-> (sp <= PW'(MAX_VERTICES)))
    else $error("dfs stack pointer past vertex count");

  // queue head never passes the tail
  assert property (@(posedge clk) disable iff (rst)
    (state == S_BFS_SCAN || state == S_BFS_DEQ) |-> (head <= tail))
    else $error("bfs queue head past tail");

  // the start vertex stays marked for the whole walk
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DFS_EV || state == S_DFS_POP || state == S_BFS_SCAN ||
     state == S_BFS_DEQ || state == S_FLUSH) |-> visited[0])
    else $error("start vertex not marked visited during walk");

  // the final vertex goes out flagged and the block returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("walk end did not emit a last transaction");

  // a walk emits only with a free output slot
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the graph traversal block
`timescale 1ns / 100ps

module testbench;
  import gdbt_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
  } graph_op_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vtx;
    logic                last;
  } visit_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // vertex_a [5:0], vertex_b [11:6], zero pad
  logic [ACTION_W-1:0]  s_tuser = '0;  // action [1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // visited_vertex [5:0], zero pad
  logic                 m_tlast;

  graph_op_t   op_pending[$];
  visit_t      visit_expect[$];
  logic [63:0] graph_rows [64];
  graph_op_t   op_next;
  visit_t      visit_head;
  int          error_count = 0;
  int          ops_accepted = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        rx_hold = 1'b0;

  graph_dfs_bfs_traversal dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [VERTEX_W-1:0] lowest_vertex(input logic [63:0] m);
    logic [VERTEX_W-1:0] lo;
    lo = '0;
    for (int i = 63; i >= 0; i--) begin
      if (m[i]) lo = i[VERTEX_W-1:0];
    end
    return lo;
  endfunction

  // update the adjacency copy and queue the visit order a walk produces
  function automatic void predict_op(input logic [ACTION_W-1:0] act,
                                     input logic [VERTEX_W-1:0] va,
                                     input logic [VERTEX_W-1:0] vb);
    logic [63:0]         seen;
    logic [63:0]         cand;
    logic [VERTEX_W-1:0] path[$];
    logic [VERTEX_W-1:0] frontier[$];
    logic [VERTEX_W-1:0] u;
    logic [VERTEX_W-1:0] w;
    int                  head;
    visit_t              v;
    path.delete();
    frontier.delete();
    case (act)
      ACT_ADD_EDGE: begin
        graph_rows[va][vb] = 1'b1;
        graph_rows[vb][va] = 1'b1;
      end
      ACT_REMOVE: begin
        for (int i = 0; i < 64; i++) graph_rows[i][va] = 1'b0;
      end
      ACT_DFS: begin
        // frontier used as the walk stack, top at the back
        seen = 64'd1;
        path.push_back('0);
        frontier.push_back('0);
        while (frontier.size() > 0) begin
          u = frontier[frontier.size() - 1];
          cand = graph_rows[u] & ~seen;
          if (cand == '0) begin
            void'(frontier.pop_back());
          end else begin
            w = lowest_vertex(cand);
            seen[w] = 1'b1;
            path.push_back(w);
            frontier.push_back(w);
          end
        end
      end
      ACT_BFS: begin
        seen = 64'd1;
        frontier.push_back('0);
        head = 0;
        while (head < frontier.size()) begin
          u = frontier[head];
          head++;
          cand = graph_rows[u] & ~seen;
          path.push_back(u);
          while (cand != '0) begin
            w = lowest_vertex(cand);
            cand[w] = 1'b0;
            seen[w] = 1'b1;
            frontier.push_back(w);
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < path.size(); i++) begin
      v.vtx = path[i];
      v.last = (i == path.size() - 1);
      visit_expect.push_back(v);
    end
  endfunction

  // idle mix by progress: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (ops_accepted < 60) begin
      send_idle_pct = 29;
      recv_idle_pct = 65;
    end else if (ops_accepted < 120) begin
      send_idle_pct = 65;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // driver: offer the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (op_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_next = op_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - 2 * VERTEX_W){1'b0}}, op_next.vb, op_next.va};
        s_tuser <= op_next.act;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (ops_accepted < 70) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_op(s_tuser, s_tdata[VERTEX_W-1:0], s_tdata[2*VERTEX_W-1:VERTEX_W]);
        ops_accepted <= ops_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        if (visit_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction: vertex %0d last %0b",
                                    m_tdata[VERTEX_W-1:0], m_tlast));
        end else begin
          visit_head = visit_expect.pop_front();
          if (m_tdata[VERTEX_W-1:0] !== visit_head.vtx)
            report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                      m_tdata[VERTEX_W-1:0], visit_head.vtx));
          if (m_tlast !== visit_head.last)
            report_mismatch($sformatf("last %0b, expected %0b on vertex %0d",
                                      m_tlast, visit_head.last, visit_head.vtx));
        end
      end
    end
  end

  task automatic queue_op(input logic [ACTION_W-1:0] act,
                          input logic [VERTEX_W-1:0] va,
                          input logic [VERTEX_W-1:0] vb);
    graph_op_t op;
    op.act = act;
    op.va = va;
    op.vb = vb;
    op_pending.push_back(op);
  endtask

  // mostly a small cluster around vertex 0 so walks stay connected
  function automatic logic [VERTEX_W-1:0] pick_vertex();
    if ($urandom_range(99) < 75) return VERTEX_W'($urandom_range(11));
    return VERTEX_W'($urandom_range(63));
  endfunction

  // stimulus and end of run
  initial begin
    int n_edges;
    int n_random;
    logic [VERTEX_W-1:0] rv;
    for (int i = 0; i < 64; i++) graph_rows[i] = '0;

    // isolated start on an empty graph
    queue_op(ACT_DFS, 6'd0, 6'd0);
    queue_op(ACT_BFS, 6'd63, 6'd63);
    // self loops are ignored by the walk
    queue_op(ACT_ADD_EDGE, 6'd0, 6'd0);
    queue_op(ACT_ADD_EDGE, 6'd63, 6'd63);
    queue_op(ACT_DFS, 6'd0, 6'd0);
    // small graph reaching the top vertex
    queue_op(ACT_ADD_EDGE, 6'd0, 6'd63);
    queue_op(ACT_ADD_EDGE, 6'd63, 6'd62);
    queue_op(ACT_ADD_EDGE, 6'd0, 6'd5);
    queue_op(ACT_ADD_EDGE, 6'd5, 6'd2);
    queue_op(ACT_ADD_EDGE, 6'd2, 6'd1);
    queue_op(ACT_ADD_EDGE, 6'd1, 6'd63);
    queue_op(ACT_DFS, 6'd0, 6'd0);
    queue_op(ACT_BFS, 6'd0, 6'd0);
    // remove vertex 0: its own row survives and the walk still starts there
    queue_op(ACT_REMOVE, 6'd0, 6'd42);
    queue_op(ACT_DFS, 6'd0, 6'd0);
    queue_op(ACT_BFS, 6'd0, 6'd0);
    // remove the top vertex, then add edges among 62, 42 and 21 that do not touch it
    queue_op(ACT_REMOVE, 6'd63, 6'd0);
    queue_op(ACT_DFS, 6'd21, 6'd42);
    queue_op(ACT_ADD_EDGE, 6'd62, 6'd42);
    queue_op(ACT_ADD_EDGE, 6'd42, 6'd21);
    queue_op(ACT_BFS, 6'd0, 6'd0);
    queue_op(ACT_DFS, 6'd0, 6'd0);

    // random episodes: grow the graph, sometimes remove, then walk
    n_random = 0;
    while (n_random < 150) begin
      n_edges = $urandom_range(8, 2);
      for (int i = 0; i < n_edges; i++) begin
        queue_op(ACT_ADD_EDGE, pick_vertex(), pick_vertex());
        n_random++;
      end
      if ($urandom_range(99) < 35) begin
        rv = pick_vertex();
        queue_op(ACT_REMOVE, rv, VERTEX_W'($urandom_range(63)));
        n_random++;
      end
      queue_op($urandom_range(1) ? ACT_DFS : ACT_BFS, VERTEX_W'($urandom_range(63)),
               VERTEX_W'($urandom_range(63)));
      n_random++;
      if ($urandom_range(99) < 30) begin
        queue_op($urandom_range(1) ? ACT_DFS : ACT_BFS, VERTEX_W'($urandom_range(63)),
                 VERTEX_W'($urandom_range(63)));
        n_random++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for all items to be taken, then for all visits to arrive
    while (op_pending.size() > 0 || s_tvalid) @(posedge clk);
    while (visit_expect.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
